/* sv/dpv_pkg.sv */
// ----------------------------------------------------------------------------
// dpv_pkg
// Shared types, constants and elaboration-time trigonometry for the
// hit position to voxel index converter.
// ----------------------------------------------------------------------------
package dpv_pkg;

    typedef longint unsigned u64_t;

    localparam int POS_W      = 24;
    localparam int VOX_W      = 6;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int COEF_BITS  = 30;
    localparam int COEF_W     = 32;
    localparam int PITCH_W    = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam u64_t PI_Q30   = 64'd3373259426;

    // Defaults for the top level parameters
    localparam int DEF_ROT_X_MDEG        = 0;
    localparam int DEF_ROT_Y_MDEG        = 0;
    localparam int DEF_ROT_Z_MDEG        = 0;
    localparam int DEF_MAX_BARS          = 64;
    localparam int DEF_MAX_DOUBLE_PLANES = 32;

    // Register reset values
    localparam logic signed [23:0] RST_CENTER_X     = 24'sd0;
    localparam logic signed [23:0] RST_CENTER_Y     = 24'sd0;
    localparam logic signed [23:0] RST_FRONT_Z      = 24'sd1433600;
    localparam logic [22:0]        RST_BAR_LENGTH   = 23'd256000;
    localparam logic [19:0]        RST_THICKNESS_XY = 20'd5120;
    localparam logic [19:0]        RST_THICKNESS_Z  = 20'd5120;
    localparam logic [6:0]         RST_BARS         = 7'd50;
    localparam logic [5:0]         RST_DPLANES      = 6'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_FRONT_Z,
        REG_BAR_LENGTH,
        REG_THICKNESS_XY,
        REG_THICKNESS_Z,
        REG_BARS_PER_PLANE,
        REG_DOUBLE_PLANES
    } cfg_reg_t;

    // Outcome of the range check ahead of the divider
    typedef enum logic [1:0] {
        QC_DIV,
        QC_LOW,
        QC_HIGH
    } quant_class_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } pos_t;

    typedef struct packed {
        logic [VOX_W-1:0] voxel_x;
        logic [VOX_W-1:0] voxel_y;
        logic [VOX_W-1:0] voxel_z;
    } voxel_t;

    // Sine or cosine of an angle in millidegrees, Q2.30, by Taylor series
    function automatic longint trig_q30(input longint mdeg, input logic want_sin);
        longint a;
        logic   sneg;
        logic   cneg;
        u64_t   x;
        u64_t   x2;
        u64_t   term;
        longint ss;
        longint cs;
        longint one;
        one  = longint'(1) << COEF_BITS;
        cneg = 1'b0;
        a = mdeg % 360000;
        if (a > 180000) a = a - 360000;
        if (a < -180000) a = a + 360000;
        sneg = (a < 0);
        if (sneg) a = -a;
        if (a > 90000)
        begin
            a    = 180000 - a;
            cneg = 1'b1;
        end
        x  = (u64_t'(a) * PI_Q30 + 64'd90000) / 64'd180000;
        x2 = (x * x) >> COEF_BITS;
        // Sine terms up to the 15th power
        term = x;
        ss   = longint'(x);
        term = ((term * x2) >> COEF_BITS) / 64'd6;
        ss   = ss - longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd20;
        ss   = ss + longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd42;
        ss   = ss - longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd72;
        ss   = ss + longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd110;
        ss   = ss - longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd156;
        ss   = ss + longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd210;
        ss   = ss - longint'(term);
        // Cosine terms up to the 14th power
        term = u64_t'(one);
        cs   = one;
        term = ((term * x2) >> COEF_BITS) / 64'd2;
        cs   = cs - longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd12;
        cs   = cs + longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd30;
        cs   = cs - longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd56;
        cs   = cs + longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd90;
        cs   = cs - longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd132;
        cs   = cs + longint'(term);
        term = ((term * x2) >> COEF_BITS) / 64'd182;
        cs   = cs - longint'(term);
        if (ss < 0) ss = 0;
        if (ss > one) ss = one;
        if (cs < 0) cs = 0;
        if (cs > one) cs = one;
        if (want_sin) return sneg ? -ss : ss;
        return cneg ? -cs : cs;
    endfunction

endpackage

/* sv/dpv_fifo.sv */
// ----------------------------------------------------------------------------
// dpv_fifo
// Short register queue between the front stage and the back pipeline.
// ----------------------------------------------------------------------------
module dpv_fifo
    import dpv_pkg::*;
#(
    parameter int W     = 84,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    output logic         q_full,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         q_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == CW'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rdata   = mem_reg[rp_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (rd)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

/* sv/dpv_front.sv */
// ----------------------------------------------------------------------------
// dpv_front
// Input stage: takes a hit beat and removes the detector centre and the
// z offset to the detector middle before handing it to the queue.
// ----------------------------------------------------------------------------
module dpv_front
    import dpv_pkg::*;
#(
    parameter int BW = 28,
    parameter int XW = 26
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  pos_t                    pos,
    input  logic signed [23:0]      center_x,
    input  logic signed [23:0]      center_y,
    input  logic signed [23:0]      front_z,
    input  logic [XW-1:0]           half,
    input  logic                    q_full,
    output logic                    q_wr,
    output logic [3*BW-1:0]         q_data
);
    logic f_valid_reg, f_valid_next;
    pos_t f_pos_reg;
    logic accept;
    logic signed [BW-1:0] dx;
    logic signed [BW-1:0] dy;
    logic signed [BW-1:0] dz;

    assign full   = f_valid_reg && q_full;
    assign accept = push && !full;
    assign q_wr   = f_valid_reg && !q_full;

    // Hold or replace the front beat
    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (q_wr)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_pos_reg <= pos;
        end
    end

    // Remove centre and middle-of-detector offset
    always_comb
    begin
        dx = BW'(f_pos_reg.pos_x) - BW'(center_x);
        dy = BW'(f_pos_reg.pos_y) - BW'(center_y);
        dz = BW'(f_pos_reg.pos_z) - BW'(front_z) - $signed(BW'(half));
    end

    assign q_data = {dz, dy, dx};

endmodule

/* sv/dpv_rot.sv */
// ----------------------------------------------------------------------------
// dpv_rot
// One plane rotation by fixed Q2.30 coefficients, two stages: products,
// then sum with rounding half away from zero.
// ----------------------------------------------------------------------------
module dpv_rot
    import dpv_pkg::*;
#(
    parameter int     AW  = 29,
    parameter longint COS = 64'sd1073741824,
    parameter longint SIN = 64'sd0
)
(
    input  logic                 clk,
    input  logic                 adv,
    input  logic signed [AW-1:0] a,
    input  logic signed [AW-1:0] b,
    input  logic signed [AW-1:0] p,
    output logic signed [AW-1:0] a_o,
    output logic signed [AW-1:0] b_o,
    output logic signed [AW-1:0] p_o
);
    localparam int PW = AW + COEF_W;
    localparam logic signed [COEF_W-1:0] COS_C = COEF_W'(COS);
    localparam logic signed [COEF_W-1:0] SIN_C = COEF_W'(SIN);
    localparam logic signed [PW:0] RHALF   = (PW+1)'(longint'(1) << (COEF_BITS - 1));
    localparam logic signed [PW:0] RHALFM1 = (PW+1)'((longint'(1) << (COEF_BITS - 1)) - 1);

    logic signed [PW-1:0] pac_reg, pbs_reg, pas_reg, pbc_reg;
    logic signed [AW-1:0] p1_reg;
    logic signed [PW:0]   s1, s2, t1, t2;
    logic signed [AW-1:0] a_reg, b_reg, p2_reg;

    // Stage one: products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pac_reg <= a * COS_C;
            pbs_reg <= b * SIN_C;
            pas_reg <= a * SIN_C;
            pbc_reg <= b * COS_C;
            p1_reg  <= p;
        end
    end

    // Stage two: sum and round
    always_comb
    begin
        s1 = (PW+1)'(pac_reg) - (PW+1)'(pbs_reg);
        s2 = (PW+1)'(pas_reg) + (PW+1)'(pbc_reg);
        t1 = s1 + (s1[PW] ? RHALFM1 : RHALF);
        t2 = s2 + (s2[PW] ? RHALFM1 : RHALF);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg  <= t1[COEF_BITS+AW-1:COEF_BITS];
            b_reg  <= t2[COEF_BITS+AW-1:COEF_BITS];
            p2_reg <= p1_reg;
        end
    end

    assign a_o = a_reg;
    assign b_o = b_reg;
    assign p_o = p2_reg;

endmodule

/* sv/dpv_quant.sv */
// ----------------------------------------------------------------------------
// dpv_quant
// Quantise one axis: range check, scale by the last index, then a
// pipelined restoring divide by twice the extent, one quotient bit a stage.
// ----------------------------------------------------------------------------
module dpv_quant
    import dpv_pkg::*;
#(
    parameter int AW = 29,
    parameter int XW = 26,
    parameter int QW = 6
)
(
    input  logic                 clk,
    input  logic                 adv,
    input  logic signed [AW-1:0] v,
    input  logic [XW-1:0]        off,
    input  logic [XW-1:0]        ext,
    input  logic [QW-1:0]        m,
    output logic [VOX_W-1:0]     idx
);
    localparam int NW   = ((AW > XW) ? AW : XW) + 2;
    localparam int NUMW = XW + 1 + QW;

    logic signed [NW-1:0] num2;
    logic                 neg;
    logic                 over;
    quant_class_t         cls;
    logic [XW:0]          dvs;

    logic [XW:0]          num_a_reg;
    quant_class_t         cls_a_reg;
    logic [NUMW-1:0]      rem_reg [QW+1];
    logic [QW-1:0]        quo_reg [QW+1];
    quant_class_t         cls_reg [QW+1];
    logic [VOX_W-1:0]     idx_reg;

    assign dvs = {ext, 1'b0};

    // Classify against zero and the full extent
    always_comb
    begin
        num2 = (NW'(v) <<< 1) + $signed(NW'(off));
        neg  = num2[NW-1];
        over = (num2[NW-2:0] > (NW-1)'(dvs));
        priority if (neg)
            cls = QC_LOW;
        else if (over)
            cls = QC_HIGH;
        else if (ext == '0)
            cls = QC_LOW;
        else
            cls = QC_DIV;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_a_reg <= num2[XW:0];
            cls_a_reg <= cls;
            // Scale by the last index and add half the divisor
            rem_reg[0] <= NUMW'(num_a_reg) * NUMW'(m) + NUMW'(ext);
            quo_reg[0] <= '0;
            cls_reg[0] <= cls_a_reg;
            // One quotient bit per stage, most significant first
            for (int s = 0; s < QW; s++)
            begin
                if (rem_reg[s] >= (NUMW'(dvs) << (QW - 1 - s)))
                begin
                    rem_reg[s+1] <= rem_reg[s] - (NUMW'(dvs) << (QW - 1 - s));
                    quo_reg[s+1] <= quo_reg[s] | (QW'(1) << (QW - 1 - s));
                end
                else
                begin
                    rem_reg[s+1] <= rem_reg[s];
                    quo_reg[s+1] <= quo_reg[s];
                end
                cls_reg[s+1] <= cls_reg[s];
            end
        end
    end

    // Pick the index and drop bits beyond the field
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unique case (cls_reg[QW])
                QC_LOW:  idx_reg <= '0;
                QC_HIGH: idx_reg <= VOX_W'(m);
                QC_DIV:  idx_reg <= VOX_W'(quo_reg[QW]);
                default: idx_reg <= '0;
            endcase
        end
    end

    assign idx = idx_reg;

endmodule

/* sv/detector_position_to_voxel_core.sv */
// ----------------------------------------------------------------------------
// detector_position_to_voxel_core
// Converts a 3-D hit position to voxel indices of a bar detector: offset
// removal, three fixed rotations, corner shift and per-axis quantisation.
//
//   channel   direction  handshake        payload
//   hit       in         push / full      pos    (pos_x, pos_y, pos_z)
//   voxel     out        empty / pop      voxel  (voxel_x, voxel_y, voxel_z)
//   config    in         cfg_wr_en        cfg_index, cfg_data
//
// One hit per cycle sustained while results are popped. A hit passes the
// front stage, the queue, the entry stage, the three rotations and the
// quantiser, whose divider has a quotient width QW (6 at default
// sizes).
// Reset clears all control state and loads the register reset values;
// derived extents are registered and follow a register write in the next cycle.
// An unpopped result freezes the back pipeline; the four-entry queue then
// fills and full rises once the front stage also holds a beat.
// ----------------------------------------------------------------------------
module detector_position_to_voxel_core
    import dpv_pkg::*;
#(
    parameter int ROT_X_MDEG        = DEF_ROT_X_MDEG,
    parameter int ROT_Y_MDEG        = DEF_ROT_Y_MDEG,
    parameter int ROT_Z_MDEG        = DEF_ROT_Z_MDEG,
    parameter int MAX_BARS          = DEF_MAX_BARS,
    parameter int MAX_DOUBLE_PLANES = DEF_MAX_DOUBLE_PLANES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pos_t                 pos,
    output logic                 empty,
    input  logic                 pop,
    output voxel_t               voxel,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int NBW    = $clog2(MAX_BARS + 1);
    localparam int DPW    = $clog2(MAX_DOUBLE_PLANES + 1);
    localparam int MAXIDX = ((MAX_BARS - 1) > (2 * MAX_DOUBLE_PLANES - 1)) ?
                            (MAX_BARS - 1) : (2 * MAX_DOUBLE_PLANES - 1);
    localparam int QW     = $clog2(MAXIDX + 1);
    localparam int XW0    = ((PITCH_W + NBW) > (PITCH_W + 1 + DPW)) ?
                            (PITCH_W + NBW) : (PITCH_W + 1 + DPW);
    localparam int XW     = (XW0 > 23) ? XW0 : 23;
    localparam int BW     = (((POS_W + 1) > (PITCH_W + DPW)) ?
                            (POS_W + 1) : (PITCH_W + DPW)) + 2;
    localparam int AW     = BW + 1;
    localparam int LAT    = QW + 10;

    localparam longint COS_X = trig_q30(-longint'(ROT_X_MDEG), 1'b0);
    localparam longint SIN_X = trig_q30(-longint'(ROT_X_MDEG), 1'b1);
    localparam longint COS_Y = trig_q30(-longint'(ROT_Y_MDEG), 1'b0);
    localparam longint SIN_Y = trig_q30(-longint'(ROT_Y_MDEG), 1'b1);
    localparam longint COS_Z = trig_q30(-longint'(ROT_Z_MDEG), 1'b0);
    localparam longint SIN_Z = trig_q30(-longint'(ROT_Z_MDEG), 1'b1);

    // Configuration registers
    logic signed [23:0] center_x_reg, center_y_reg, front_z_reg;
    logic [22:0]        bar_length_reg;
    logic [19:0]        thickness_xy_reg, thickness_z_reg;
    logic [6:0]         bars_reg;
    logic [5:0]         dplanes_reg;

    // Derived extents
    logic [NBW-1:0]     n_next;
    logic [DPW-1:0]     dp_next;
    logic [XW-1:0]      ext_reg, ext_next;
    logic [XW-1:0]      half_reg, half_next;
    logic [XW-1:0]      e_reg;
    logic [QW-1:0]      mxy_reg, mxy_next;
    logic [QW-1:0]      mz_reg, mz_next;

    logic               q_wr, q_rd, q_full, q_empty;
    logic [3*BW-1:0]    q_wdata, q_rdata;

    logic               adv;
    logic [LAT-1:0]     vld_reg, vld_next;
    logic signed [BW-1:0] s0_x_reg, s0_y_reg, s0_z_reg;

    logic signed [AW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
    logic [VOX_W-1:0]     idx_x, idx_y, idx_z;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= RST_CENTER_X;
            center_y_reg     <= RST_CENTER_Y;
            front_z_reg      <= RST_FRONT_Z;
            bar_length_reg   <= RST_BAR_LENGTH;
            thickness_xy_reg <= RST_THICKNESS_XY;
            thickness_z_reg  <= RST_THICKNESS_Z;
            bars_reg         <= RST_BARS;
            dplanes_reg      <= RST_DPLANES;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:       center_x_reg     <= cfg_data[23:0];
                REG_CENTER_Y:       center_y_reg     <= cfg_data[23:0];
                REG_FRONT_Z:        front_z_reg      <= cfg_data[23:0];
                REG_BAR_LENGTH:     bar_length_reg   <= cfg_data[22:0];
                REG_THICKNESS_XY:   thickness_xy_reg <= cfg_data[19:0];
                REG_THICKNESS_Z:    thickness_z_reg  <= cfg_data[19:0];
                REG_BARS_PER_PLANE: bars_reg         <= cfg_data[6:0];
                REG_DOUBLE_PLANES:  dplanes_reg      <= cfg_data[5:0];
                default:            ;
            endcase
        end
    end

    // Clamp counts and form extents and last indices
    always_comb
    begin
        if (bars_reg == '0)
            n_next = NBW'(1);
        else if (32'(bars_reg) > 32'(MAX_BARS))
            n_next = NBW'(MAX_BARS);
        else
            n_next = NBW'(bars_reg);
        if (dplanes_reg == '0)
            dp_next = DPW'(1);
        else if (32'(dplanes_reg) > 32'(MAX_DOUBLE_PLANES))
            dp_next = DPW'(MAX_DOUBLE_PLANES);
        else
            dp_next = DPW'(dplanes_reg);
        ext_next  = XW'(thickness_xy_reg) * XW'(n_next);
        half_next = XW'(thickness_z_reg) * XW'(dp_next);
        mxy_next  = QW'(n_next) - QW'(1);
        mz_next   = (QW'(dp_next) << 1) - QW'(1);
    end

    always_ff @(posedge clk)
    begin
        ext_reg  <= ext_next;
        half_reg <= half_next;
        e_reg    <= half_next << 1;
        mxy_reg  <= mxy_next;
        mz_reg   <= mz_next;
    end

    dpv_front #(
        .BW (BW),
        .XW (XW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .pos      (pos),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .front_z  (front_z_reg),
        .half     (half_reg),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_data   (q_wdata)
    );

    dpv_fifo #(
        .W     (3 * BW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_rd),
        .rdata   (q_rdata),
        .q_empty (q_empty)
    );

    // Advance the back pipeline unless a result waits unpopped
    assign adv   = !vld_reg[LAT-1] || pop;
    assign q_rd  = adv && !q_empty;
    assign empty = !vld_reg[LAT-1];

    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
        begin
            vld_next = {vld_reg[LAT-2:0], q_rd};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Entry stage of the back pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_x_reg <= q_rdata[BW-1:0];
            s0_y_reg <= q_rdata[2*BW-1:BW];
            s0_z_reg <= q_rdata[3*BW-1:2*BW];
        end
    end

    // Rotate back about z, then y, then x
    dpv_rot #(.AW(AW), .COS(COS_Z), .SIN(SIN_Z)) u_rot_z (
        .clk (clk), .adv (adv),
        .a   (AW'(s0_x_reg)), .b (AW'(s0_y_reg)), .p (AW'(s0_z_reg)),
        .a_o (x1), .b_o (y1), .p_o (z1)
    );

    dpv_rot #(.AW(AW), .COS(COS_Y), .SIN(SIN_Y)) u_rot_y (
        .clk (clk), .adv (adv),
        .a   (z1), .b (x1), .p (y1),
        .a_o (z2), .b_o (x2), .p_o (y2)
    );

    dpv_rot #(.AW(AW), .COS(COS_X), .SIN(SIN_X)) u_rot_x (
        .clk (clk), .adv (adv),
        .a   (y2), .b (z2), .p (x2),
        .a_o (y3), .b_o (z3), .p_o (x3)
    );

    dpv_quant #(.AW(AW), .XW(XW), .QW(QW)) u_quant_x (
        .clk (clk), .adv (adv), .v (x3),
        .off (XW'(bar_length_reg)), .ext (ext_reg), .m (mxy_reg),
        .idx (idx_x)
    );

    dpv_quant #(.AW(AW), .XW(XW), .QW(QW)) u_quant_y (
        .clk (clk), .adv (adv), .v (y3),
        .off (XW'(bar_length_reg)), .ext (ext_reg), .m (mxy_reg),
        .idx (idx_y)
    );

    dpv_quant #(.AW(AW), .XW(XW), .QW(QW)) u_quant_z (
        .clk (clk), .adv (adv), .v (z3),
        .off (e_reg), .ext (e_reg), .m (mz_reg),
        .idx (idx_z)
    );

    assign voxel.voxel_x = idx_x;
    assign voxel.voxel_y = idx_y;
    assign voxel.voxel_z = idx_z;

`ifndef SYNTHESIS
    // A waiting result freezes every stage of the back pipeline
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(vld_reg))
        else $error("back pipeline moved while a result was held");

    // Input backpressure only comes from a full queue
    a_full_src: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_full)
        else $error("full raised with room in the queue");

    // A beat taken from the queue lands in the entry stage
    a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |=> vld_reg[0])
        else $error("queue beat lost at the entry stage");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for detector_position_to_voxel_core. Hits go in through
// the push/full queue port in random bursts, voxel results are drained
// through empty/pop on a stall pattern of their own, and each result is
// compared with a built-in predictor that tracks the register settings.
// Several register settings are run, the extremes and the clamped cases
// among them.
// ----------------------------------------------------------------------------
module tb;
    import dpv_pkg::*;

    localparam int   IDLE_LIMIT  = 20000;
    localparam int   SETTLE      = 40;
    localparam int   PHASE_HITS  = 220;
    localparam longint ONE_Q30   = longint'(1) << COEF_BITS;

    logic   clk;
    logic   rst_n;
    logic   push;
    logic   full;
    pos_t   pos;
    logic   empty;
    logic   pop;
    voxel_t voxel;
    logic   cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    detector_position_to_voxel_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pos       (pos),
        .empty     (empty),
        .pop       (pop),
        .voxel     (voxel),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the register file
    longint cx, cy, fz, blen, pitch_xy, pitch_z, bars, dplanes;
    longint sn_x, cs_x, sn_y, cs_y, sn_z, cs_z;

    voxel_t pending_voxels[$];
    int     errors;
    int     idle_cycles;

    // Typed expectation attached to the beat being offered
    logic   typed_ok;
    voxel_t typed_vox;

    // Sender burst state
    int burst_left;
    int gap_left;

    // Receiver stall pattern
    int pop_mode;
    int pop_span;
    int pop_tick;

    typedef struct {
        pos_t   hit;
        logic   known;
        voxel_t vox;
    } hit_row_t;

    hit_row_t directed_hits[$];

    // Sine or cosine in Q2.30 of an angle in millidegrees
    function automatic longint angle_q30(input longint mdeg, input logic give_sin);
        longint a;
        logic   neg_s;
        logic   neg_c;
        longint unsigned xr, xsq, t;
        longint s_acc;
        longint c_acc;
        neg_c = 1'b0;
        a = mdeg % 360000;
        if (a > 180000) a -= 360000;
        if (a < -180000) a += 360000;
        neg_s = a < 0;
        if (neg_s) a = -a;
        if (a > 90000)
        begin
            a = 180000 - a;
            neg_c = 1'b1;
        end
        xr  = (longint'(a) * PI_Q30 + 90000) / 180000;
        xsq = (xr * xr) >> COEF_BITS;
        t = xr;
        s_acc = longint'(xr);
        for (int k = 1; k <= 7; k++)
        begin
            t = ((t * xsq) >> COEF_BITS) / longint'((2 * k) * (2 * k + 1));
            s_acc = (k % 2) ? s_acc - longint'(t) : s_acc + longint'(t);
        end
        t = ONE_Q30;
        c_acc = ONE_Q30;
        for (int k = 1; k <= 7; k++)
        begin
            t = ((t * xsq) >> COEF_BITS) / longint'((2 * k - 1) * (2 * k));
            c_acc = (k % 2) ? c_acc - longint'(t) : c_acc + longint'(t);
        end
        if (s_acc < 0) s_acc = 0;
        if (s_acc > ONE_Q30) s_acc = ONE_Q30;
        if (c_acc < 0) c_acc = 0;
        if (c_acc > ONE_Q30) c_acc = ONE_Q30;
        if (give_sin) return neg_s ? -s_acc : s_acc;
        return neg_c ? -c_acc : c_acc;
    endfunction

    // Drop a Q2.30 product to whole units, half away from zero
    function automatic longint round_q30(input longint p);
        longint h;
        h = longint'(1) << (COEF_BITS - 1);
        if (p < 0) return -(((-p) + h) >>> COEF_BITS);
        return (p + h) >>> COEF_BITS;
    endfunction

    function automatic logic [VOX_W-1:0] bin_index(input longint twice_v, input longint ext,
                                                   input longint last);
        if (twice_v < 0) return '0;
        if (twice_v > 2 * ext) return last[VOX_W-1:0];
        if (ext == 0) return '0;
        return VOX_W'((twice_v * last + ext) / (2 * ext));
    endfunction

    // Voxel triple a hit should land in under the current registers
    function automatic voxel_t hit_to_voxel(input pos_t h);
        longint n, dp, half, x, y, z, r1, r2, ext;
        voxel_t v;
        n  = (bars < 1) ? 1 : (bars > DEF_MAX_BARS ? DEF_MAX_BARS : bars);
        dp = (dplanes < 1) ? 1 :
             (dplanes > DEF_MAX_DOUBLE_PLANES ? DEF_MAX_DOUBLE_PLANES : dplanes);
        half = pitch_z * dp;
        x = longint'(h.pos_x) - cx;
        y = longint'(h.pos_y) - cy;
        z = longint'(h.pos_z) - fz - half;
        // undo rotation about z, then y, then x
        r1 = round_q30(x * cs_z - y * sn_z);
        r2 = round_q30(x * sn_z + y * cs_z);
        x = r1;
        y = r2;
        r1 = round_q30(z * cs_y - x * sn_y);
        r2 = round_q30(z * sn_y + x * cs_y);
        z = r1;
        x = r2;
        r1 = round_q30(y * cs_x - z * sn_x);
        r2 = round_q30(y * sn_x + z * cs_x);
        y = r1;
        z = r2;
        ext = pitch_xy * n;
        v.voxel_x = bin_index(2 * x + blen, ext, n - 1);
        v.voxel_y = bin_index(2 * y + blen, ext, n - 1);
        v.voxel_z = bin_index(2 * (z + half), 2 * half, 2 * dp - 1);
        return v;
    endfunction

    function automatic longint pick(input longint lo, input longint hi);
        return lo + longint'($urandom_range(int'(hi - lo)));
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: change stall pattern every so often
    always @(negedge clk)
    begin
        if (pop_tick >= pop_span)
        begin
            pop_mode = $urandom_range(3);
            pop_span = $urandom_range(200, 30);
            pop_tick = 0;
        end
        pop_tick++;
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(1) == 1);
            2: pop <= ($urandom_range(4) == 0);
            default: pop <= ((pop_tick / 8) % 2 == 0);
        endcase
    end

    // Monitor: record accepted hits, check accepted voxels, watch for hangs
    always @(posedge clk)
    begin
        voxel_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (push && !full)
            begin
                pending_voxels.push_back(typed_ok ? typed_vox : hit_to_voxel(pos));
                idle_cycles = 0;
            end
            if (pop && !empty)
            begin
                idle_cycles = 0;
                if (pending_voxels.size() == 0)
                begin
                    $error("voxel beat with nothing pending: %0d %0d %0d",
                           voxel.voxel_x, voxel.voxel_y, voxel.voxel_z);
                    errors++;
                end
                else
                begin
                    want = pending_voxels.pop_front();
                    if (voxel.voxel_x !== want.voxel_x)
                    begin
                        $error("voxel_x: expected %0d, got %0d", want.voxel_x, voxel.voxel_x);
                        errors++;
                    end
                    if (voxel.voxel_y !== want.voxel_y)
                    begin
                        $error("voxel_y: expected %0d, got %0d", want.voxel_y, voxel.voxel_y);
                        errors++;
                    end
                    if (voxel.voxel_z !== want.voxel_z)
                    begin
                        $error("voxel_z: expected %0d, got %0d", want.voxel_z, voxel.voxel_z);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) idle_cycles = 0;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Offer one hit, honouring the burst pattern, and hold until taken
    task automatic send_hit(input pos_t h, input logic known, input voxel_t v);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
        end
        while (gap_left > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            @(posedge clk);
            gap_left--;
        end
        @(negedge clk);
        typed_ok  = known;
        typed_vox = v;
        push <= 1'b1;
        pos  <= h;
        forever
        begin
            @(posedge clk);
            if (!full) break;
        end
        burst_left--;
    endtask

    // Hold the sender until every voxel has come back, then let the pipe settle
    task automatic drain;
        @(negedge clk);
        push <= 1'b0;
        while (pending_voxels.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input longint val);
        logic [CFG_W-1:0] d;
        d = val[CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        case (idx)
            REG_CENTER_X:       cx       = longint'(signed'(d));
            REG_CENTER_Y:       cy       = longint'(signed'(d));
            REG_FRONT_Z:        fz       = longint'(signed'(d));
            REG_BAR_LENGTH:     blen     = longint'(d[22:0]);
            REG_THICKNESS_XY:   pitch_xy = longint'(d[19:0]);
            REG_THICKNESS_Z:    pitch_z  = longint'(d[19:0]);
            REG_BARS_PER_PLANE: bars     = longint'(d[6:0]);
            default:            dplanes  = longint'(d[5:0]);
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_regs(input longint a, input longint b, input longint c,
                             input longint d, input longint e, input longint f,
                             input longint g, input longint k);
        write_reg(REG_CENTER_X, a);
        write_reg(REG_CENTER_Y, b);
        write_reg(REG_FRONT_Z, c);
        write_reg(REG_BAR_LENGTH, d);
        write_reg(REG_THICKNESS_XY, e);
        write_reg(REG_THICKNESS_Z, f);
        write_reg(REG_BARS_PER_PLANE, g);
        write_reg(REG_DOUBLE_PLANES, k);
        repeat (4) @(posedge clk);
    endtask

    // Random hits: mostly inside or just around the detector, some anywhere
    task automatic random_hits(input int count);
        pos_t   h;
        voxel_t none;
        longint sx, sz, half;
        none = '0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 7)
            begin
                sx   = blen / 2 + blen / 8 + 2;
                half = pitch_z * ((dplanes < 1) ? 1 : (dplanes > 32 ? 32 : dplanes));
                sz   = 2 * half + half / 4 + 2;
                h.pos_x = POS_W'(cx + pick(-sx, sx));
                h.pos_y = POS_W'(cy + pick(-sx, sx));
                h.pos_z = POS_W'(fz + pick(-(half / 4) - 2, sz));
            end
            else
            begin
                h = pos_t'({$urandom, $urandom, $urandom});
            end
            send_hit(h, 1'b0, none);
        end
    endtask

    initial
    begin
        voxel_t none;
        voxel_t vx;
        pos_t   h;
        none = '0;
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        pop_mode = 0;
        pop_span = 0;
        pop_tick = 0;
        typed_ok = 1'b0;
        typed_vox = '0;
        rst_n = 1'b0;
        push = 1'b0;
        pos = '0;
        pop = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;

        cx = RST_CENTER_X;
        cy = RST_CENTER_Y;
        fz = RST_FRONT_Z;
        blen = RST_BAR_LENGTH;
        pitch_xy = RST_THICKNESS_XY;
        pitch_z = RST_THICKNESS_Z;
        bars = RST_BARS;
        dplanes = RST_DPLANES;
        sn_x = angle_q30(-longint'(DEF_ROT_X_MDEG), 1'b1);
        cs_x = angle_q30(-longint'(DEF_ROT_X_MDEG), 1'b0);
        sn_y = angle_q30(-longint'(DEF_ROT_Y_MDEG), 1'b1);
        cs_y = angle_q30(-longint'(DEF_ROT_Y_MDEG), 1'b0);
        sn_z = angle_q30(-longint'(DEF_ROT_Z_MDEG), 1'b1);
        cs_z = angle_q30(-longint'(DEF_ROT_Z_MDEG), 1'b0);

        // Directed hits under reset registers; typed values where obvious
        directed_hits.push_back('{'{24'sd0, 24'sd0, 24'sd1433600}, 1'b1, '{6'd25, 6'd25, 6'd0}});
        directed_hits.push_back('{'{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, 1'b1,
                                  '{6'd49, 6'd49, 6'd59}});
        directed_hits.push_back('{'{24'sh800000, 24'sh800000, 24'sh800000}, 1'b1,
                                  '{6'd0, 6'd0, 6'd0}});
        directed_hits.push_back('{'{-24'sd128000, -24'sd128000, 24'sd1433600}, 1'b1,
                                  '{6'd0, 6'd0, 6'd0}});
        directed_hits.push_back('{'{24'sd128000, 24'sd128000, 24'sd1740800}, 1'b1,
                                  '{6'd49, 6'd49, 6'd59}});
        directed_hits.push_back('{'{-24'sd128001, 24'sd128001, 24'sd1433599}, 1'b0, none});
        directed_hits.push_back('{'{24'sd128001, -24'sd127999, 24'sd1740801}, 1'b0, none});
        directed_hits.push_back('{'{24'sd2560, -24'sd2561, 24'sd1587200}, 1'b0, none});
        directed_hits.push_back('{'{-24'sd1, 24'sd1, 24'sd1436160}, 1'b0, none});
        directed_hits.push_back('{'{24'sd125440, -24'sd125440, 24'sd1738240}, 1'b0, none});
        directed_hits.push_back('{'{24'sh555555, 24'shAAAAAA, 24'sh555555}, 1'b0, none});
        directed_hits.push_back('{'{24'shAAAAAA, 24'sh555555, 24'shAAAAAA}, 1'b0, none});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_hits[i])
            send_hit(directed_hits[i].hit, directed_hits[i].known, directed_hits[i].vox);
        random_hits(PHASE_HITS);
        drain();

        // Widest extents and the far corners of the signed ranges
        load_regs(-8388608, 8388607, -8388608, 8388607, 1048575, 1048575, 64, 32);
        random_hits(PHASE_HITS);
        drain();

        // Zero pitch with clamped-up counts: zero bars and planes act as one
        load_regs(0, 0, 0, 1, 0, 0, 0, 0);
        for (int i = -2; i <= 2; i++)
        begin
            h = '{POS_W'(i), POS_W'(-i), POS_W'(i)};
            send_hit(h, 1'b0, none);
        end
        random_hits(80);
        drain();

        // Counts above the maximum are clamped down
        load_regs(1000, -1000, 5000, 6400, 100, 200, 127, 63);
        random_hits(PHASE_HITS);
        drain();

        // Assorted settings
        for (int p = 0; p < 3; p++)
        begin
            load_regs(pick(-4000000, 4000000), pick(-4000000, 4000000), pick(-4000000, 4000000),
                      pick(1, 600000), pick(1, 20000), pick(1, 20000),
                      pick(1, 64), pick(1, 32));
            random_hits(PHASE_HITS);
            drain();
        end

        // Back to the reset values
        load_regs(RST_CENTER_X, RST_CENTER_Y, RST_FRONT_Z, RST_BAR_LENGTH,
                  RST_THICKNESS_XY, RST_THICKNESS_Z, RST_BARS, RST_DPLANES);
        random_hits(PHASE_HITS);
        drain();

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
sv/dpv_pkg.sv
sv/dpv_fifo.sv
sv/dpv_front.sv
sv/dpv_rot.sv
sv/dpv_quant.sv
sv/detector_position_to_voxel_core.sv
tb/tb.sv
